// ===== rtl/csm_pkg.sv =====
package csm_pkg;

    // Field widths fixed by the request and result formats.
    localparam int IDX_W       = 10;
    localparam int VAL_W       = 32;
    localparam int ROW_W       = 16;
    localparam int SUM_W       = 64;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 80;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Width that can hold any legal vector length for the range check.
    localparam int RANGE_W     = 17;

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_NONZERO = 2'd1,
        REQ_EMPTY   = 2'd2,
        REQ_RESTART = 2'd3
    } t_req;

    typedef struct packed {
        t_req                     kind;
        logic [IDX_W-1:0]         index;
        logic signed [VAL_W-1:0]  value;
        logic                     last;
        logic                     in_range;
    } t_cmd;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

// ===== rtl/csm_front.sv =====
module csm_front #(
    parameter int VECTOR_LENGTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_kind,
    input  logic [csm_pkg::IDX_W-1:0]       i_index,
    input  logic signed [csm_pkg::VAL_W-1:0] i_value,
    input  logic                            i_last,
    output logic                            o_cmd_valid,
    output csm_pkg::t_cmd                   o_cmd,
    input  logic                            i_cmd_pop
);

    localparam logic [csm_pkg::RANGE_W-1:0] VLEN = csm_pkg::RANGE_W'(VECTOR_LENGTH);

    csm_pkg::t_cmd                    r_queue [csm_pkg::QUEUE_DEPTH];
    logic [csm_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [csm_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [csm_pkg::QCNT_W-1:0]       r_count;
    logic [csm_pkg::QCNT_W-1:0]       n_count;
    csm_pkg::t_cmd                    w_cmd;
    logic                             w_push;
    logic                             w_pop;

    // Classify the request: decode its kind and check the index against
    // the vector length once, so the back never needs the wide compare.
    always_comb begin
        w_cmd.kind     = csm_pkg::t_req'(i_kind);
        w_cmd.index    = i_index;
        w_cmd.value    = i_value;
        w_cmd.last     = i_last;
        w_cmd.in_range = {{(csm_pkg::RANGE_W-csm_pkg::IDX_W){1'b0}}, i_index} < VLEN;
    end

    assign o_ready     = (r_count != csm_pkg::QCNT_W'(csm_pkg::QUEUE_DEPTH));
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_count != '0);
    assign w_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_queue[r_rd_ptr];

    always_comb begin
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= csm_pkg::QCNT_W'(csm_pkg::QUEUE_DEPTH))
        else $error("command queue level exceeds its depth");

endmodule

// ===== rtl/csm_back.sv =====
module csm_back #(
    parameter int VECTOR_LENGTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    input  csm_pkg::t_cmd                     i_cmd,
    output logic                              o_cmd_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [csm_pkg::ROW_W-1:0]         o_row,
    output logic signed [csm_pkg::SUM_W-1:0]  o_sum,
    output logic                              o_ovf
);

    // Only the first 1024 entries are reachable by a 10-bit index.
    localparam int DEPTH  = (VECTOR_LENGTH < (1 << csm_pkg::IDX_W)) ?
                            VECTOR_LENGTH : (1 << csm_pkg::IDX_W);
    localparam int ADDR_W = $clog2(DEPTH);

    logic [csm_pkg::VAL_W-1:0]          r_mem [DEPTH];

    logic                               w_adv;
    logic [ADDR_W-1:0]                  w_addr;

    // Stage 1: vector read.
    logic                               r_s1_valid;
    csm_pkg::t_req                      r_s1_kind;
    logic signed [csm_pkg::VAL_W-1:0]   r_s1_value;
    logic                               r_s1_last;
    logic                               r_s1_in_range;
    logic signed [csm_pkg::VAL_W-1:0]   r_s1_vec;
    logic signed [csm_pkg::VAL_W-1:0]   w_operand;

    // Stage 2: product.
    logic                               r_s2_valid;
    csm_pkg::t_req                      r_s2_kind;
    logic                               r_s2_last;
    logic signed [csm_pkg::SUM_W-1:0]   r_s2_prod;
    logic signed [csm_pkg::SUM_W-1:0]   w_prod;

    // Row state.
    logic signed [csm_pkg::SUM_W-1:0]   r_acc;
    logic [csm_pkg::ROW_W-1:0]          r_row;
    logic                               r_flag;
    logic signed [csm_pkg::SUM_W-1:0]   w_raw;
    logic                               w_sat;
    logic signed [csm_pkg::SUM_W-1:0]   w_acc_next;
    logic                               w_emit;

    // Output register.
    logic                               r_out_valid;
    logic [csm_pkg::ROW_W-1:0]          r_out_row;
    logic signed [csm_pkg::SUM_W-1:0]   r_out_sum;
    logic                               r_out_ovf;

    // The whole back pipeline moves together whenever the output register
    // is free or being drained this cycle.
    assign w_adv     = !r_out_valid || i_ready;
    assign o_cmd_pop = w_adv && i_cmd_valid;
    assign w_addr    = i_cmd.index[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.in_range) begin
            if (i_cmd.kind == csm_pkg::REQ_LOAD) begin
                r_mem[w_addr] <= i_cmd.value;
            end
            if (i_cmd.kind == csm_pkg::REQ_NONZERO) begin
                r_s1_vec <= r_mem[w_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_kind     <= i_cmd.kind;
            r_s1_value    <= i_cmd.value;
            r_s1_last     <= i_cmd.last;
            r_s1_in_range <= i_cmd.in_range;
            r_s2_kind     <= r_s1_kind;
            r_s2_last     <= r_s1_last;
            r_s2_prod     <= w_prod;
        end
    end

    // A column past the vector end multiplies by zero.
    assign w_operand = r_s1_in_range ? r_s1_vec : '0;
    assign w_prod    = csm_pkg::SUM_W'(r_s1_value) * csm_pkg::SUM_W'(w_operand);

    // Saturating accumulate: overflow only when both addends share a sign
    // and the sum does not.
    assign w_raw      = r_acc + r_s2_prod;
    assign w_sat      = (r_acc[csm_pkg::SUM_W-1] == r_s2_prod[csm_pkg::SUM_W-1]) &&
                        (w_raw[csm_pkg::SUM_W-1] != r_acc[csm_pkg::SUM_W-1]);
    assign w_acc_next = w_sat ? (r_acc[csm_pkg::SUM_W-1] ? csm_pkg::SUM_MIN : csm_pkg::SUM_MAX)
                              : w_raw;

    // A row closes on an empty-row request or on a nonzero marked as last.
    assign w_emit = r_s2_valid && ((r_s2_kind == csm_pkg::REQ_EMPTY) ||
                    ((r_s2_kind == csm_pkg::REQ_NONZERO) && r_s2_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_acc       <= '0;
            r_row       <= '0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= w_emit;
                r_s1_valid  <= i_cmd_valid;
                r_s2_valid  <= r_s1_valid;
                if (r_s2_valid) begin
                    case (r_s2_kind)
                        csm_pkg::REQ_NONZERO: begin
                            if (r_s2_last) begin
                                r_row       <= r_row + 1'b1;
                                r_acc       <= '0;
                                r_flag      <= 1'b0;
                            end else begin
                                r_acc  <= w_acc_next;
                                r_flag <= r_flag || w_sat;
                            end
                        end
                        csm_pkg::REQ_EMPTY: begin
                            r_row       <= r_row + 1'b1;
                            r_acc       <= '0;
                            r_flag      <= 1'b0;
                        end
                        csm_pkg::REQ_RESTART: begin
                            r_row  <= '0;
                            r_acc  <= '0;
                            r_flag <= 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s2_valid) begin
            r_out_row <= r_row;
            if (r_s2_kind == csm_pkg::REQ_NONZERO) begin
                r_out_sum <= w_acc_next;
                r_out_ovf <= r_flag || w_sat;
            end else begin
                r_out_sum <= r_acc;
                r_out_ovf <= r_flag;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_row   = r_out_row;
    assign o_sum   = r_out_sum;
    assign o_ovf   = r_out_ovf;

    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_s2_valid && (r_s2_kind == csm_pkg::REQ_EMPTY ||
        (r_s2_kind == csm_pkg::REQ_NONZERO && r_s2_last)) |=> r_out_valid)
        else $error("finished row did not reach the output register");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_s2_valid && r_s2_kind == csm_pkg::REQ_RESTART
        |=> r_row == '0 && r_acc == '0 && !r_flag)
        else $error("restart did not clear the row state");

    a_row_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_adv && r_s2_valid) |=> $stable(r_row) && $stable(r_acc))
        else $error("row state changed without a command");

endmodule

// ===== rtl/csr_sparse_matvec.sv =====
// Sparse matrix times dense vector, rows streamed in CSR order, fixed point.
// Slave side: one request per handshake. s_axis_tuser gives the request
// kind (load vector element, matrix nonzero, empty row, restart row
// numbering), s_axis_tdata the index and the Q16.16 value, and
// s_axis_tlast marks the last nonzero of a row.
// Master side: one result per finished row, the row number and the
// saturated Q32.32 row sum on m_axis_tdata, the overflow flag on tuser.
// Load the vector elements before any nonzero that reads them.
// Throughput: one request per cycle while results are taken, since each
// request needs a single vector memory access and one multiply-accumulate.
// Path: a row's closing request is written into the command queue, then
// passes the vector read, the multiplier register and the
// accumulator/output register before its result is valid.
// Reset clears the command queue, the pipeline, the row counter, the
// accumulator and the overflow flag; the vector store keeps its contents.
// When the receiver stalls, the output holds and the back pipeline freezes;
// the four-entry command queue keeps taking requests until it is full, and
// only then s_axis_tready falls.
module csr_sparse_matvec #(
    parameter int VECTOR_LENGTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [9:0] item_index, [41:10] item_value, [47:42] zero
    input  logic [csm_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]                          s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] row_index, [79:16] row_sum
    output logic [csm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // [0] overflowed
    output logic                                m_axis_tuser
);

    logic                               w_cmd_valid;
    csm_pkg::t_cmd                      w_cmd;
    logic                               w_cmd_pop;
    logic [csm_pkg::ROW_W-1:0]          w_row;
    logic signed [csm_pkg::SUM_W-1:0]   w_sum;

    csm_front #(
        .VECTOR_LENGTH (VECTOR_LENGTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_kind      (s_axis_tuser),
        .i_index     (s_axis_tdata[csm_pkg::IDX_W-1:0]),
        .i_value     (s_axis_tdata[csm_pkg::IDX_W+csm_pkg::VAL_W-1:csm_pkg::IDX_W]),
        .i_last      (s_axis_tlast),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    csm_back #(
        .VECTOR_LENGTH (VECTOR_LENGTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_row       (w_row),
        .o_sum       (w_sum),
        .o_ovf       (m_axis_tuser)
    );

    assign m_axis_tdata = {w_sum, w_row};

endmodule
